[hdl/scopechk_pkg.sv]
`timescale 1ns / 1ps
package scopechk_pkg;

  localparam int REGIONS = 8;
  localparam int FRAMES  = 16;

  localparam int IDX_W  = $clog2(REGIONS);
  localparam int FIDX_W = $clog2(FRAMES);
  localparam int CNT_W  = 4;
  localparam int DEP_W  = 5;
  localparam int BADR_W = IDX_W + 1;
  localparam int FADR_W = FIDX_W + IDX_W;

  typedef logic [127:0] region_t;

  typedef enum logic [3:0] {
    CMD_CHECK    = 4'd0,
    CMD_BASE     = 4'd1,
    CMD_LIMIT    = 4'd2,
    CMD_DELEGATE = 4'd3,
    CMD_DEL_MOVE = 4'd4,
    CMD_SUB      = 4'd5,
    CMD_ENTER    = 4'd6,
    CMD_EXIT     = 4'd7,
    CMD_ON       = 4'd8,
    CMD_OFF      = 4'd9
  } cmd_t;

  typedef enum logic [3:0] {
    ERR_OK        = 4'd0,
    ERR_OVERFLOW  = 4'd1,
    ERR_EMPTY     = 4'd2,
    ERR_NO_FIT    = 4'd3,
    ERR_A_FULL    = 4'd4,
    ERR_LIM_BASE  = 4'd5,
    ERR_A_EMPTY   = 4'd6,
    ERR_B_FULL    = 4'd7,
    ERR_MISS      = 4'd8,
    ERR_NOT_TOP   = 4'd9,
    ERR_SUB_OUT   = 4'd10,
    ERR_SUB_ORDER = 4'd11
  } err_t;

  localparam logic [1:0] MODE_STRICT = 2'd0;
  localparam logic [1:0] MODE_DEBUG  = 2'd2;

endpackage

[hdl/scope_region_stack_checker_top.sv]
`timescale 1ns / 1ps
// Channel  Signals                               Direction
// in       in_valid/in_stall, in_cmd..in_privilege  command in
// out      out_valid/out_stall, out_allowed..       one result per command
// cfg      cfg_valid/cfg_ready, cfg_data           enforcing mode write
//
// One command at a time. Trivial commands pass the decode and final steps;
// check, sub and delegate scan bank A top-down, a read and an evaluate step
// per region; enter/exit copy a frame, a read and a write step per region,
// through the bank and frame memory ports (one read, one write each).
// Synchronous active-low reset clears control state and region valid bits, so
// no clearing pass is needed. A stalled result holds ST_FIN until transferred.
module scope_region_stack_checker_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              in_cmd,
  input  logic [63:0]             in_address,
  input  logic [63:0]             in_length_or_limit,
  input  logic                    in_access_kind,
  input  logic [1:0]              in_privilege,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_allowed,
  output logic                    out_fault,
  output logic                    out_fault_kind,
  output logic [3:0]              out_error_code,
  output logic                    out_enforcing,
  output logic                    out_privilege_match,
  output logic [3:0]              out_active_count,
  output logic [3:0]              out_delegate_count,
  output logic [4:0]              out_stack_depth,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_data
);
  import scopechk_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_DEC     = 9'b000000010,
    ST_SCAN_RD = 9'b000000100,
    ST_SCAN_EV = 9'b000001000,
    ST_RMW_RD  = 9'b000010000,
    ST_RMW_WR  = 9'b000100000,
    ST_CP_RD   = 9'b001000000,
    ST_CP_WR   = 9'b010000000,
    ST_FIN     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]  cmd_r;
  logic [63:0] addr_r, len_r, last_r, last_nxt;
  logic        kind_r;
  logic [1:0]  priv_r;
  logic [1:0]  mode_r;
  logic        on_r, on_nxt;
  logic [1:0]  emode_r, emode_nxt;
  logic        sel_r, sel_nxt;
  logic [CNT_W-1:0] cnt_r [2];
  logic [CNT_W-1:0] cnt_nxt [2];
  logic [DEP_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] fsz_r [FRAMES];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic        allowed_r, allowed_nxt, fault_r, fault_nxt, fkind_r, fkind_nxt;
  err_t        err_r, err_nxt;

  // bank memory: {base, limit}, address {physical bank, slot}
  region_t          bmem [2*REGIONS];
  region_t          brq_r;
  logic             bvq_r;
  logic [2*REGIONS-1:0] bvld_r;
  logic             bw_en;
  logic [BADR_W-1:0] bw_addr, br_addr;
  region_t          bw_data, brd;

  region_t          fmem [FRAMES*REGIONS];
  region_t          frq_r;
  logic             fw_en;
  logic [FADR_W-1:0] fw_addr, fr_addr;
  logic             fsz_we;

  logic             out_valid_r;

  logic             a, b;
  logic [CNT_W-1:0] na, nb, popn, cp_last;
  logic [FIDX_W-1:0] top;
  logic [CNT_W:0]   fit_sum;
  logic [63:0]      chk_last;
  logic             chk_wraps, hit, fin_enter, fin_exit;
  logic             in_xfer;

  assign a        = sel_r;
  assign b        = ~sel_r;
  assign na       = cnt_r[a];
  assign nb       = cnt_r[b];
  assign top      = FIDX_W'(depth_r - 1'b1);
  assign popn     = fsz_r[top];
  assign fit_sum  = {1'b0, popn} + {1'b0, nb};
  assign cp_last  = (cmd_r == CMD_ENTER) ? na - 1'b1 : popn - 1'b1;
  assign chk_last = (len_r == 64'd0) ? addr_r : addr_r + (len_r - 64'd1);
  assign chk_wraps = (len_r != 64'd0) && (chk_last < addr_r);
  assign brd      = bvq_r ? brq_r : '0;
  assign hit      = (addr_r >= brd[127:64]) && (last_r <= brd[63:0]);

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign cfg_ready = (state_r == ST_IDLE) && rst_n;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    last_nxt    = last_r;
    on_nxt      = on_r;
    emode_nxt   = emode_r;
    sel_nxt     = sel_r;
    cnt_nxt[0]  = cnt_r[0];
    cnt_nxt[1]  = cnt_r[1];
    depth_nxt   = depth_r;
    idx_nxt     = idx_r;
    allowed_nxt = allowed_r;
    fault_nxt   = fault_r;
    fkind_nxt   = fkind_r;
    err_nxt     = err_r;
    bw_en       = 1'b0;
    bw_addr     = {a, idx_r};
    bw_data     = {addr_r, len_r};
    br_addr     = {a, idx_r};
    fw_en       = 1'b0;
    fw_addr     = {depth_r[FIDX_W-1:0], idx_r};
    fr_addr     = {top, idx_r};
    fsz_we      = 1'b0;
    fin_enter   = 1'b0;
    fin_exit    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          allowed_nxt = 1'b0;
          fault_nxt   = 1'b0;
          fkind_nxt   = 1'b0;
          err_nxt     = ERR_OK;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        state_nxt = ST_FIN;
        idx_nxt   = IDX_W'(na - 1'b1);
        unique case (cmd_r)
          CMD_CHECK: begin
            last_nxt = chk_last;
            if (!on_r) begin
              allowed_nxt = 1'b1;
            end else if (chk_wraps || na == '0) begin
              fault_nxt = 1'b1;
              fkind_nxt = kind_r;
              if (mode_r >= MODE_DEBUG) on_nxt = 1'b0;
            end else begin
              state_nxt = ST_SCAN_RD;
            end
          end
          CMD_BASE, CMD_LIMIT: begin
            idx_nxt = IDX_W'(na);
            if (na >= CNT_W'(REGIONS)) err_nxt = ERR_A_FULL;
            else state_nxt = ST_RMW_RD;
          end
          CMD_DELEGATE, CMD_DEL_MOVE: begin
            last_nxt = addr_r;
            if (na == '0) err_nxt = ERR_A_EMPTY;
            else if (nb >= CNT_W'(REGIONS)) err_nxt = ERR_B_FULL;
            else if (cmd_r == CMD_DELEGATE && addr_r == 64'd0) err_nxt = ERR_OK;
            else state_nxt = ST_SCAN_RD;
          end
          CMD_SUB: begin
            last_nxt = len_r;
            if (len_r < addr_r) begin
              err_nxt = ERR_SUB_ORDER;
            end else if (on_r) begin
              if (na == '0) err_nxt = ERR_SUB_OUT;
              else state_nxt = ST_SCAN_RD;
            end else if (na >= CNT_W'(REGIONS)) begin
              err_nxt = ERR_A_FULL;
            end else begin
              bw_en   = 1'b1;
              bw_addr = {a, IDX_W'(na)};
              cnt_nxt[a] = na + 1'b1;
            end
          end
          CMD_ENTER: begin
            idx_nxt = '0;
            if (depth_r >= DEP_W'(FRAMES)) begin
              err_nxt = ERR_OVERFLOW;
            end else begin
              fsz_we = 1'b1;
              if (na == '0) fin_enter = 1'b1;
              else state_nxt = ST_CP_RD;
            end
          end
          CMD_EXIT: begin
            idx_nxt = '0;
            if (depth_r == '0) err_nxt = ERR_EMPTY;
            else if (fit_sum >= (CNT_W+1)'(REGIONS)) err_nxt = ERR_NO_FIT;
            else if (popn == '0) fin_exit = 1'b1;
            else state_nxt = ST_CP_RD;
          end
          CMD_ON: begin
            emode_nxt = priv_r;
            on_nxt    = 1'b1;
          end
          CMD_OFF: on_nxt = 1'b0;
          default: ;
        endcase
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_EV;
      ST_SCAN_EV: begin
        state_nxt = ST_FIN;
        if (hit) begin
          priority case (cmd_r)
            CMD_CHECK: allowed_nxt = 1'b1;
            CMD_SUB: begin
              if (na >= CNT_W'(REGIONS)) begin
                err_nxt = ERR_A_FULL;
              end else begin
                bw_en   = 1'b1;
                bw_addr = {a, IDX_W'(na)};
                cnt_nxt[a] = na + 1'b1;
              end
            end
            default: begin
              if (cmd_r == CMD_DEL_MOVE && idx_r != IDX_W'(na - 1'b1)) begin
                err_nxt = ERR_NOT_TOP;
              end else begin
                bw_en   = 1'b1;
                bw_addr = {b, IDX_W'(nb)};
                bw_data = brd;
                cnt_nxt[b] = nb + 1'b1;
                if (cmd_r == CMD_DEL_MOVE) cnt_nxt[a] = na - 1'b1;
              end
            end
          endcase
        end else if (idx_r != '0) begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_SCAN_RD;
        end else begin
          priority case (cmd_r)
            CMD_CHECK: begin
              fault_nxt = 1'b1;
              fkind_nxt = kind_r;
              if (mode_r >= MODE_DEBUG) on_nxt = 1'b0;
            end
            CMD_SUB: err_nxt = ERR_SUB_OUT;
            default: if (mode_r == MODE_STRICT) err_nxt = ERR_MISS;
          endcase
        end
      end
      ST_RMW_RD: state_nxt = ST_RMW_WR;
      ST_RMW_WR: begin
        state_nxt = ST_FIN;
        if (cmd_r == CMD_BASE) begin
          bw_en   = 1'b1;
          bw_data = {addr_r, brd[63:0]};
        end else if (brd[127:64] > addr_r) begin
          err_nxt = ERR_LIM_BASE;
        end else begin
          bw_en   = 1'b1;
          bw_data = {brd[127:64], addr_r};
          cnt_nxt[a] = na + 1'b1;
        end
      end
      ST_CP_RD: state_nxt = ST_CP_WR;
      ST_CP_WR: begin
        if (cmd_r == CMD_ENTER) begin
          fw_en = 1'b1;
        end else begin
          bw_en   = 1'b1;
          bw_addr = {b, IDX_W'(nb + CNT_W'(idx_r))};
          bw_data = frq_r;
        end
        if (idx_r == cp_last[IDX_W-1:0]) begin
          state_nxt = ST_FIN;
          if (cmd_r == CMD_ENTER) fin_enter = 1'b1;
          else fin_exit = 1'b1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_CP_RD;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // scope change: old A is saved or dropped, B takes over
    if (fin_enter) begin
      depth_nxt  = depth_r + 1'b1;
      cnt_nxt[a] = '0;
      sel_nxt    = ~sel_r;
    end
    if (fin_exit) begin
      cnt_nxt[b] = nb + popn;
      cnt_nxt[a] = '0;
      depth_nxt  = depth_r - 1'b1;
      sel_nxt    = ~sel_r;
      if (depth_r == DEP_W'(1)) begin
        cnt_nxt[b] = '0;
        on_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bw_en) bmem[bw_addr] <= bw_data;
    brq_r <= bmem[br_addr];
    bvq_r <= bvld_r[br_addr];
    if (fw_en) fmem[fw_addr] <= brd;
    frq_r <= fmem[fr_addr];
    if (fsz_we) fsz_r[depth_r[FIDX_W-1:0]] <= na;
    if (in_xfer) begin
      cmd_r  <= in_cmd;
      addr_r <= in_address;
      len_r  <= in_length_or_limit;
      kind_r <= in_access_kind;
      priv_r <= in_privilege;
    end
    last_r      <= last_nxt;
    idx_r       <= idx_nxt;
    allowed_r   <= allowed_nxt;
    fault_r     <= fault_nxt;
    fkind_r     <= fkind_nxt;
    err_r       <= err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= '0;
      on_r        <= 1'b0;
      emode_r     <= '0;
      sel_r       <= 1'b0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      depth_r     <= '0;
      bvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      on_r     <= on_nxt;
      emode_r  <= emode_nxt;
      sel_r    <= sel_nxt;
      cnt_r[0] <= cnt_nxt[0];
      cnt_r[1] <= cnt_nxt[1];
      depth_r  <= depth_nxt;
      if (cfg_valid && cfg_ready) mode_r <= cfg_data;
      if (bw_en) bvld_r[bw_addr] <= 1'b1;
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
      out_allowed         <= allowed_r;
      out_fault           <= fault_r;
      out_fault_kind      <= fkind_r;
      out_error_code      <= err_r;
      out_enforcing       <= on_r;
      out_privilege_match <= on_r && (priv_r == emode_r);
      out_active_count    <= cnt_r[sel_r];
      out_delegate_count  <= cnt_r[~sel_r];
      out_stack_depth     <= depth_r;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CNT_W'(REGIONS) && cnt_r[1] <= CNT_W'(REGIONS))
    else $error("bank count above capacity");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEP_W'(FRAMES))
    else $error("frame depth above capacity");
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_DEC)
    else $error("accepted command not decoded");
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    bw_en |-> (state_r == ST_DEC || state_r == ST_SCAN_EV ||
               state_r == ST_RMW_WR || state_r == ST_CP_WR))
    else $error("bank write outside a write step");
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside final step");

endmodule

[bench/scope_region_stack_checker_top_tb.sv]
`timescale 1ns / 1ps
module scope_region_stack_checker_top_tb;
  import scopechk_pkg::*;

  typedef struct packed {
    logic       allowed;
    logic       fault;
    logic       fault_kind;
    logic [3:0] error_code;
    logic       enforcing;
    logic       privilege_match;
    logic [3:0] active_count;
    logic [3:0] delegate_count;
    logic [4:0] stack_depth;
  } verdict_t;

  // Golden model of the scope checker plus the queue of predicted verdicts.
  class scope_scoreboard;
    logic [1:0]  mode_reg;
    logic        on_q;
    logic [1:0]  priv_mode;
    logic        sel;
    logic [63:0] rbase[2][REGIONS];
    logic [63:0] rlim[2][REGIONS];
    int          cnt[2];
    int          fsize[FRAMES];
    logic [63:0] fbase[FRAMES][REGIONS];
    logic [63:0] flim[FRAMES][REGIONS];
    int          depth;
    verdict_t    pending[$];
    int          errors;

    function void clear();
      mode_reg = MODE_STRICT; on_q = 0; priv_mode = 0; sel = 0;
      cnt[0] = 0; cnt[1] = 0; depth = 0; errors = 0;
      for (int b = 0; b < 2; b++)
        for (int i = 0; i < REGIONS; i++) begin
          rbase[b][i] = '0; rlim[b][i] = '0;
        end
      pending.delete();
    endfunction

    function bit covered(logic [63:0] lo, logic [63:0] hi);
      int a;
      a = sel;
      for (int i = cnt[a] - 1; i >= 0; i--)
        if (lo >= rbase[a][i] && hi <= rlim[a][i]) return 1;
      return 0;
    endfunction

    function int lookup(logic [63:0] ad);
      int a;
      a = sel;
      for (int i = cnt[a] - 1; i >= 0; i--)
        if (rbase[a][i] <= ad && rlim[a][i] >= ad) return i;
      return -1;
    endfunction

    function void flip();
      sel = ~sel;
      cnt[~sel] = 0;
    endfunction

    function void note_command(logic [3:0] cmd, logic [63:0] ad, logic [63:0] len,
                               logic kind, logic [1:0] priv);
      verdict_t v;
      int a, b, na, nb, hit, top, popn;
      logic [63:0] last;
      v = '0;
      a = sel; b = a ^ 1; na = cnt[a]; nb = cnt[b];
      case (cmd)
        CMD_CHECK: begin
          last = (len == 0) ? ad : ad + (len - 1);
          if (!on_q || (!(len != 0 && last < ad) && covered(ad, last))) v.allowed = 1;
          else begin
            v.fault = 1; v.fault_kind = kind;
            if (mode_reg >= MODE_DEBUG) on_q = 0;
          end
        end
        CMD_BASE:
          if (na >= REGIONS) v.error_code = ERR_A_FULL;
          else rbase[a][na] = ad;
        CMD_LIMIT:
          if (na >= REGIONS) v.error_code = ERR_A_FULL;
          else if (rbase[a][na] > ad) v.error_code = ERR_LIM_BASE;
          else begin
            rlim[a][na] = ad; cnt[a] = na + 1;
          end
        CMD_DELEGATE, CMD_DEL_MOVE: begin
          if (na == 0) v.error_code = ERR_A_EMPTY;
          else if (nb >= REGIONS) v.error_code = ERR_B_FULL;
          else if (!(cmd == CMD_DELEGATE && ad == 0)) begin
            hit = lookup(ad);
            if (hit < 0) begin
              if (mode_reg == MODE_STRICT) v.error_code = ERR_MISS;
            end else if (cmd == CMD_DEL_MOVE && hit != na - 1) v.error_code = ERR_NOT_TOP;
            else begin
              rbase[b][nb] = rbase[a][hit]; rlim[b][nb] = rlim[a][hit];
              cnt[b] = nb + 1;
              if (cmd == CMD_DEL_MOVE) cnt[a] = na - 1;
            end
          end
        end
        CMD_SUB:
          if (len < ad) v.error_code = ERR_SUB_ORDER;
          else if (on_q && !covered(ad, len)) v.error_code = ERR_SUB_OUT;
          else if (na >= REGIONS) v.error_code = ERR_A_FULL;
          else begin
            rbase[a][na] = ad; rlim[a][na] = len; cnt[a] = na + 1;
          end
        CMD_ENTER:
          if (depth >= FRAMES) v.error_code = ERR_OVERFLOW;
          else begin
            fsize[depth] = na;
            for (int i = 0; i < na; i++) begin
              fbase[depth][i] = rbase[a][i]; flim[depth][i] = rlim[a][i];
            end
            depth++; cnt[a] = 0; flip();
          end
        CMD_EXIT:
          if (depth == 0) v.error_code = ERR_EMPTY;
          else begin
            top = depth - 1; popn = fsize[top];
            if (popn + nb >= REGIONS) v.error_code = ERR_NO_FIT;
            else begin
              for (int i = 0; i < popn; i++) begin
                rbase[b][nb + i] = fbase[top][i]; rlim[b][nb + i] = flim[top][i];
              end
              cnt[b] = nb + popn; depth = top; flip();
              if (depth == 0) begin
                cnt[sel] = 0; on_q = 0;
              end
            end
          end
        CMD_ON: begin
          priv_mode = priv; on_q = 1;
        end
        CMD_OFF: on_q = 0;
        default: ;
      endcase
      v.enforcing = on_q;
      v.privilege_match = on_q && priv == priv_mode;
      v.active_count = 4'(cnt[sel]);
      v.delegate_count = 4'(cnt[~sel]);
      v.stack_depth = 5'(depth);
      pending = {pending, v};
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [3:0] in_cmd = 0;
  logic [63:0] in_address = 0, in_length_or_limit = 0;
  logic in_access_kind = 0;
  logic [1:0] in_privilege = 0;
  logic out_valid, out_stall = 0;
  verdict_t got_v;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_data = 0;

  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  longint cycles = 0;
  scope_scoreboard sb;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  scope_region_stack_checker_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_address(in_address), .in_length_or_limit(in_length_or_limit),
    .in_access_kind(in_access_kind), .in_privilege(in_privilege),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_allowed(got_v.allowed), .out_fault(got_v.fault),
    .out_fault_kind(got_v.fault_kind), .out_error_code(got_v.error_code),
    .out_enforcing(got_v.enforcing), .out_privilege_match(got_v.privilege_match),
    .out_active_count(got_v.active_count), .out_delegate_count(got_v.delegate_count),
    .out_stack_depth(got_v.stack_depth),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) sb.check_verdict(got_v);
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_stall);
  end

  // valid stays up between back-to-back transfers; it drops only while idling
  task automatic send_cmd(logic [3:0] c, logic [63:0] ad, logic [63:0] len,
                          logic k, logic [1:0] p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_cmd <= c; in_address <= ad;
    in_length_or_limit <= len; in_access_kind <= k; in_privilege <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(c, ad, len, k, p);
    @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * REGIONS + 10) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1; cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.mode_reg = m;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed scope traffic with small addresses so checks can hit
  task automatic random_cmd();
    int r;
    logic [63:0] ad, len;
    logic [3:0] c;
    r = $urandom_range(99);
    ad = ($urandom_range(9) == 0) ? rnd64() : 64'($urandom_range(4095));
    len = ($urandom_range(9) == 0) ? rnd64() : 64'($urandom_range(300));
    if (r < 22) c = CMD_CHECK;
    else if (r < 34) c = CMD_BASE;
    else if (r < 46) begin
      c = CMD_LIMIT; ad = ad + 64'($urandom_range(2000));
    end else if (r < 54) c = CMD_DELEGATE;
    else if (r < 60) c = CMD_DEL_MOVE;
    else if (r < 68) begin
      c = CMD_SUB; len = ad + len;
    end else if (r < 78) c = CMD_ENTER;
    else if (r < 88) c = CMD_EXIT;
    else if (r < 94) c = CMD_ON;
    else if (r < 97) c = CMD_OFF;
    else c = 4'($urandom_range(15));
    send_cmd(c, ad, len, 1'($urandom_range(1)), 2'($urandom_range(3)));
  endtask

  initial begin
    logic [63:0] ones;
    ones = '1;
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    write_mode(MODE_STRICT);
    // directed: extremes and special cases
    send_cmd(CMD_CHECK, ones, 0, 1, 3);
    send_cmd(CMD_EXIT, 0, 0, 0, 0);
    send_cmd(CMD_DELEGATE, 5, 0, 0, 0);
    send_cmd(CMD_BASE, 100, 0, 0, 0);
    send_cmd(CMD_LIMIT, 50, 0, 0, 0);
    send_cmd(CMD_LIMIT, 200, 0, 0, 0);
    send_cmd(CMD_BASE, 0, 0, 0, 0);
    send_cmd(CMD_LIMIT, ones, 0, 0, 0);
    send_cmd(CMD_ON, 0, 0, 0, 3);
    send_cmd(CMD_CHECK, 150, 0, 0, 3);
    send_cmd(CMD_CHECK, ones, 2, 1, 0);
    send_cmd(CMD_SUB, 10, 5, 0, 3);
    send_cmd(CMD_SUB, 120, 180, 0, 3);
    send_cmd(CMD_DELEGATE, 0, 0, 0, 3);
    send_cmd(CMD_DELEGATE, 130, 0, 0, 3);
    send_cmd(CMD_DEL_MOVE, 130, 0, 0, 3);
    send_cmd(CMD_DEL_MOVE, 1000, 0, 0, 3);
    send_cmd(CMD_ENTER, 0, 0, 0, 0);
    send_cmd(CMD_CHECK, 130, 10, 1, 0);
    send_cmd(CMD_EXIT, 0, 0, 0, 0);
    send_cmd(CMD_EXIT, 0, 0, 0, 0);
    send_cmd(CMD_OFF, 0, 0, 0, 1);
    send_cmd(4'd15, ones, ones, 1, 3);
    send_cmd(CMD_ON, ones, ones, 1, 2);
    send_cmd(CMD_CHECK, 64'h8000_0000_0000_0000, ones, 1, 2);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 65; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 65; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      write_mode(ph == 7 ? 2'd3 : 2'(ph % 3));
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int n = 0; n < 225; n++) random_cmd();
    end

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * REGIONS + 20) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
